@@ hdl/periodic_ring_minmod_slope_top_assert.svh @@
// assertion macros for the periodic ring minmod slope block
`ifndef PERIODIC_RING_MINMOD_SLOPE_TOP_ASSERT_SVH
`define PERIODIC_RING_MINMOD_SLOPE_TOP_ASSERT_SVH

// same-cycle implication, checked on every clock edge outside reset
`define PRMM_ASSERT_NOW(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked on every clock edge outside reset
`define PRMM_ASSERT_NEXT(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ hdl/prmm_pkg.sv @@
// shared widths, codes and limits of the periodic ring minmod slope block
package prmm_pkg;

    localparam int VAL_W       = 32;
    localparam int WID_W       = 32;
    localparam int IDX_W       = 12;
    localparam int SLOPE_W     = 48;
    localparam int MAX_CELLS   = 4096;
    localparam int FRAC_SHIFT  = 29;
    localparam int MAG_W       = VAL_W + 1;
    localparam int DEN_W       = WID_W + 2;
    localparam int QUO_W       = MAG_W + FRAC_SHIFT;
    localparam int FACT_W      = 5;
    localparam int PROD_W      = SLOPE_W + FACT_W;
    localparam int WEIGH_SHIFT = 3;
    localparam int APB_AW      = 3;
    localparam int APB_DW      = 32;

    localparam logic [FACT_W-1:0] FACT_RESET = FACT_W'(12);

    localparam logic [SLOPE_W-1:0] POS_CAP = {1'b0, {(SLOPE_W-1){1'b1}}};
    localparam logic [SLOPE_W-1:0] NEG_CAP = {1'b1, {(SLOPE_W-1){1'b0}}};

    // register index, taken from paddr[2]
    localparam logic REG_LIMITER_FACTOR = 1'b0;

    typedef logic [1:0] job_t;
    localparam job_t JOB_MID  = 2'd0;
    localparam job_t JOB_END  = 2'd1;
    localparam job_t JOB_ZERO = 2'd2;

    typedef logic [1:0] slope_sel_t;
    localparam slope_sel_t SLOPE_LEFT   = 2'd0;
    localparam slope_sel_t SLOPE_CENTRE = 2'd1;
    localparam slope_sel_t SLOPE_RIGHT  = 2'd2;

endpackage

@@ hdl/prmm_div.sv @@
// restoring unsigned divider, one quotient bit per cycle
module prmm_div (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [prmm_pkg::QUO_W-1:0]  dividend,
    input  logic [prmm_pkg::DEN_W-1:0]  divisor,
    output logic                        done,
    output logic [prmm_pkg::QUO_W-1:0]  quotient
);
    import prmm_pkg::*;

    localparam int CNT_W = $clog2(QUO_W);

    logic             busy_reg;
    logic             done_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [DEN_W-1:0] rem_reg;
    logic [QUO_W-1:0] qr_reg;
    logic [DEN_W-1:0] den_reg;

    logic [DEN_W:0]   trial;
    logic             fits;
    logic [DEN_W:0]   diff_full;

    assign trial     = {rem_reg, qr_reg[QUO_W-1]};
    assign fits      = trial >= {1'b0, den_reg};
    assign diff_full = trial - {1'b0, den_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + CNT_W'(1);
                if (cnt_reg == CNT_W'(QUO_W - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= '0;
            qr_reg  <= dividend;
            den_reg <= divisor;
        end
        else if (busy_reg)
        begin
            rem_reg <= fits ? diff_full[DEN_W-1:0] : trial[DEN_W-1:0];
            qr_reg  <= {qr_reg[QUO_W-2:0], fits};
        end
    end

    assign done     = done_reg;
    assign quotient = qr_reg;

endmodule

@@ hdl/periodic_ring_minmod_slope_top.sv @@
// top level of the periodic ring minmod slope limiter
//
// cells of one periodic ring arrive in order, one item each, with the last cell
// marked by ring_end (a ring that reaches 4096 cells ends there on its own).
// for every cell the block forms left, centre and right difference slopes over
// the non-uniform widths, wrapping around the ring, and gives the generalized
// minmod of factor*left, centre and factor*right (zero if the signs disagree).
// a cell's result leaves once its right neighbor is in; cell 0 leaves last,
// flagged by ring_done. values are q16.16, widths q4.28, slopes q32.16
// saturated to 48 bits. the block takes one item at a time and holds in_stall
// high while it works. every slope is one pass through a shared restoring
// divider that makes 62 quotient bits, one per cycle, between a setup step and
// a saturate and a weighting step; a result takes three such slopes (left,
// centre, right) and a pick step. an item gives 0 to 3 results: none at a ring
// start, one in mid ring and up to three at a ring end. a result waits in the
// output register while out_stall is high; the sequencer waits in its pick
// step only when the next result is ready and that register is still full.
// limiter_factor (eighths, reset 12) is written over the apb port at offset 0.
module periodic_ring_minmod_slope_top (
    input  logic                                 clk,
    input  logic                                 rst_n,
    // configuration port
    input  logic                                 psel,
    input  logic                                 penable,
    input  logic                                 pwrite,
    input  logic [prmm_pkg::APB_AW-1:0]          paddr,
    input  logic [prmm_pkg::APB_DW-1:0]          pwdata,
    output logic [prmm_pkg::APB_DW-1:0]          prdata,
    output logic                                 pready,
    // cell items in
    input  logic                                 in_valid,
    output logic                                 in_stall,
    input  logic signed [prmm_pkg::VAL_W-1:0]    cell_value,
    input  logic [prmm_pkg::WID_W-1:0]           cell_width,
    input  logic                                 ring_end,
    // slope items out
    output logic                                 out_valid,
    input  logic                                 out_stall,
    output logic [prmm_pkg::IDX_W-1:0]           cell_index,
    output logic signed [prmm_pkg::SLOPE_W-1:0]  limited_slope,
    output logic                                 ring_done
);
    import prmm_pkg::*;

    // sequencer states
    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_SETUP  = 3'd1;
    localparam logic [2:0] ST_DIV    = 3'd2;
    localparam logic [2:0] ST_SAT    = 3'd3;
    localparam logic [2:0] ST_WEIGH  = 3'd4;
    localparam logic [2:0] ST_PICK   = 3'd5;
    localparam logic [2:0] ST_FINISH = 3'd6;

    logic [2:0]        state_reg;
    logic [2:0]        state_next;

    // configuration
    logic [FACT_W-1:0] factor_reg;

    // ring state, updated once the item is fully handled
    logic [IDX_W-1:0]  cells_seen_reg;
    logic [VAL_W-1:0]  head_v_reg [2];
    logic [WID_W-1:0]  head_w_reg [2];
    logic [VAL_W-1:0]  rec_v_reg  [2];
    logic [WID_W-1:0]  rec_w_reg  [2];

    // item being worked on
    logic [VAL_W-1:0]  cur_v_reg;
    logic [WID_W-1:0]  cur_w_reg;
    logic              last_reg;
    job_t              job_reg;
    slope_sel_t        sel_reg;

    // per-slope working registers
    logic              neg_reg;
    logic              den_zero_reg;
    logic [SLOPE_W-1:0] mag_reg;
    logic              slope_neg_reg [3];
    logic [SLOPE_W-1:0] slope_mag_reg [3];

    // output register
    logic              out_valid_reg;
    logic [IDX_W-1:0]  out_idx_reg;
    logic [SLOPE_W-1:0] out_slope_reg;
    logic              out_done_reg;

    // handshakes
    logic in_accept;
    logic out_take;
    logic cfg_write;
    logic last_now;
    logic slot_free;

    assign in_stall  = (state_reg != ST_IDLE);
    assign in_accept = in_valid && !in_stall;
    assign out_take  = out_valid_reg && !out_stall;
    assign slot_free = !out_valid_reg || !out_stall;
    assign cfg_write = psel && penable && pwrite && pready;
    assign pready    = 1'b1;
    assign prdata    = (paddr[2] == REG_LIMITER_FACTOR) ?
                       {{(APB_DW-FACT_W){1'b0}}, factor_reg} : '0;

    // a ring also ends at its last allowed position
    assign last_now = ring_end || (cells_seen_reg == IDX_W'(MAX_CELLS - 1));

    // neighbor selection for the current job
    logic [VAL_W-1:0] vl, vc, vr;
    logic [WID_W-1:0] wl, wc, wr;
    logic             k_zero, k_one;

    assign k_zero = (cells_seen_reg == '0);
    assign k_one  = (cells_seen_reg == IDX_W'(1));

    always_comb
    begin
        vl = cur_v_reg; wl = cur_w_reg;
        vc = cur_v_reg; wc = cur_w_reg;
        vr = cur_v_reg; wr = cur_w_reg;
        case (job_reg)
            JOB_MID:
            begin
                vl = rec_v_reg[1]; wl = rec_w_reg[1];
                vc = rec_v_reg[0]; wc = rec_w_reg[0];
            end
            JOB_END:
            begin
                // single-cell ring keeps all three as the cell itself
                if (k_one)
                begin
                    vl = head_v_reg[0]; wl = head_w_reg[0];
                    vr = head_v_reg[0]; wr = head_w_reg[0];
                end
                else if (!k_zero)
                begin
                    vl = rec_v_reg[0];  wl = rec_w_reg[0];
                    vr = head_v_reg[0]; wr = head_w_reg[0];
                end
            end
            JOB_ZERO:
            begin
                vc = head_v_reg[0]; wc = head_w_reg[0];
                // two-cell ring: cell 1 is both neighbors of cell 0
                if (!k_one)
                begin
                    vr = head_v_reg[1]; wr = head_w_reg[1];
                end
            end
            default:
            begin
                vl = cur_v_reg;
            end
        endcase
    end

    // difference and width sum of the selected slope
    logic signed [MAG_W-1:0] sub_a, sub_b, diff;
    logic [MAG_W-1:0]        diff_mag;
    logic [DEN_W-1:0]        den;
    logic [QUO_W-1:0]        dividend;

    always_comb
    begin
        case (sel_reg)
            SLOPE_LEFT:
            begin
                sub_a = MAG_W'(signed'(vc));
                sub_b = MAG_W'(signed'(vl));
                den   = {2'b00, wc} + {2'b00, wl};
            end
            SLOPE_RIGHT:
            begin
                sub_a = MAG_W'(signed'(vr));
                sub_b = MAG_W'(signed'(vc));
                den   = {2'b00, wr} + {2'b00, wc};
            end
            default:
            begin
                sub_a = MAG_W'(signed'(vr));
                sub_b = MAG_W'(signed'(vl));
                den   = {2'b00, wl} + {2'b00, wr} + {1'b0, wc, 1'b0};
            end
        endcase
    end

    assign diff     = sub_a - sub_b;
    assign diff_mag = diff[MAG_W-1] ? (~diff + MAG_W'(1)) : diff;
    assign dividend = {diff_mag, {FRAC_SHIFT{1'b0}}};

    // shared divider
    logic             div_start;
    logic             div_done;
    logic [QUO_W-1:0] div_quot;

    assign div_start = (state_reg == ST_SETUP);

    prmm_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (dividend),
        .divisor  (den),
        .done     (div_done),
        .quotient (div_quot)
    );

    // saturate the quotient to the 48-bit range of its sign, zero on an empty width sum
    logic [SLOPE_W-1:0] sat_cap;
    logic [SLOPE_W-1:0] sat_mag;

    assign sat_cap = neg_reg ? NEG_CAP : POS_CAP;
    assign sat_mag = den_zero_reg ? '0 :
                     (div_quot > QUO_W'(sat_cap)) ? sat_cap : div_quot[SLOPE_W-1:0];

    // weighting of the left and right slopes by factor/8, truncated toward zero, then saturated
    logic [PROD_W-1:0]  prod;
    logic [PROD_W-1:0]  scaled;
    logic [SLOPE_W-1:0] weighed;

    assign prod    = PROD_W'(mag_reg) * PROD_W'(factor_reg);
    assign scaled  = prod >> WEIGH_SHIFT;
    assign weighed = (sel_reg == SLOPE_CENTRE) ? mag_reg :
                     (scaled > PROD_W'(sat_cap)) ? sat_cap : scaled[SLOPE_W-1:0];

    // minmod over the three stored slopes
    logic               mm_zero;
    logic [SLOPE_W-1:0] mm_mag;
    logic [SLOPE_W-1:0] mm_ab;
    logic [SLOPE_W-1:0] mm_val;

    assign mm_zero = (slope_mag_reg[0] == '0) || (slope_mag_reg[1] == '0) ||
                     (slope_mag_reg[2] == '0) ||
                     (slope_neg_reg[0] != slope_neg_reg[1]) ||
                     (slope_neg_reg[1] != slope_neg_reg[2]);
    assign mm_ab   = (slope_mag_reg[1] < slope_mag_reg[0]) ?
                     slope_mag_reg[1] : slope_mag_reg[0];
    assign mm_mag  = (slope_mag_reg[2] < mm_ab) ? slope_mag_reg[2] : mm_ab;
    assign mm_val  = mm_zero ? '0 :
                     slope_neg_reg[0] ? (~mm_mag + SLOPE_W'(1)) : mm_mag;

    // index and ring flag of the current job
    logic [IDX_W-1:0] job_idx;
    logic             job_done;

    always_comb
    begin
        case (job_reg)
            JOB_MID:  job_idx = cells_seen_reg - IDX_W'(1);
            JOB_END:  job_idx = cells_seen_reg;
            default:  job_idx = '0;
        endcase
    end

    assign job_done = (job_reg == JOB_ZERO) || ((job_reg == JOB_END) && k_zero);

    // next job after the current result has left
    logic [2:0] after_pick;
    job_t       next_job;

    always_comb
    begin
        after_pick = ST_FINISH;
        next_job   = job_reg;
        case (job_reg)
            JOB_MID:
            begin
                if (last_reg)
                begin
                    after_pick = ST_SETUP;
                    next_job   = JOB_END;
                end
            end
            JOB_END:
            begin
                if (!k_zero)
                begin
                    after_pick = ST_SETUP;
                    next_job   = JOB_ZERO;
                end
            end
            default:
            begin
                after_pick = ST_FINISH;
            end
        endcase
    end

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_accept)
                begin
                    if (!k_zero && !k_one)
                        state_next = ST_SETUP;
                    else if (last_now)
                        state_next = ST_SETUP;
                    else
                        state_next = ST_FINISH;
                end
            end
            ST_SETUP:  state_next = ST_DIV;
            ST_DIV:
            begin
                if (div_done)
                    state_next = ST_SAT;
            end
            ST_SAT:    state_next = ST_WEIGH;
            ST_WEIGH:  state_next = (sel_reg == SLOPE_RIGHT) ? ST_PICK : ST_SETUP;
            ST_PICK:
            begin
                if (slot_free)
                    state_next = after_pick;
            end
            ST_FINISH: state_next = ST_IDLE;
            default:   state_next = ST_IDLE;
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            factor_reg     <= FACT_RESET;
            cells_seen_reg <= '0;
            head_v_reg[0]  <= '0;
            head_v_reg[1]  <= '0;
            head_w_reg[0]  <= '0;
            head_w_reg[1]  <= '0;
            rec_v_reg[0]   <= '0;
            rec_v_reg[1]   <= '0;
            rec_w_reg[0]   <= '0;
            rec_w_reg[1]   <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;

            if (cfg_write && (paddr[2] == REG_LIMITER_FACTOR))
                factor_reg <= pwdata[FACT_W-1:0];

            if ((state_reg == ST_PICK) && slot_free)
                out_valid_reg <= 1'b1;
            else if (out_take)
                out_valid_reg <= 1'b0;

            // commit the cell into the ring state
            if (state_reg == ST_FINISH)
            begin
                if (k_zero)
                begin
                    head_v_reg[0] <= cur_v_reg;
                    head_w_reg[0] <= cur_w_reg;
                end
                if (k_one)
                begin
                    head_v_reg[1] <= cur_v_reg;
                    head_w_reg[1] <= cur_w_reg;
                end
                rec_v_reg[1]   <= rec_v_reg[0];
                rec_w_reg[1]   <= rec_w_reg[0];
                rec_v_reg[0]   <= cur_v_reg;
                rec_w_reg[0]   <= cur_w_reg;
                cells_seen_reg <= last_reg ? '0 : cells_seen_reg + IDX_W'(1);
            end
        end
    end

    // working payload
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            cur_v_reg <= cell_value;
            cur_w_reg <= cell_width;
            last_reg  <= last_now;
            job_reg   <= (!k_zero && !k_one) ? JOB_MID : JOB_END;
            sel_reg   <= SLOPE_LEFT;
        end

        if (state_reg == ST_SETUP)
        begin
            neg_reg      <= diff[MAG_W-1];
            den_zero_reg <= (den == '0);
        end

        if (state_reg == ST_SAT)
            mag_reg <= sat_mag;

        if (state_reg == ST_WEIGH)
        begin
            slope_mag_reg[sel_reg] <= weighed;
            slope_neg_reg[sel_reg] <= neg_reg;
            sel_reg <= (sel_reg == SLOPE_LEFT) ? SLOPE_CENTRE : SLOPE_RIGHT;
        end

        if ((state_reg == ST_PICK) && slot_free)
        begin
            out_idx_reg   <= job_idx;
            out_slope_reg <= mm_val;
            out_done_reg  <= job_done;
            job_reg       <= next_job;
            sel_reg       <= SLOPE_LEFT;
        end
    end

    assign out_valid     = out_valid_reg;
    assign cell_index    = out_idx_reg;
    assign limited_slope = out_slope_reg;
    assign ring_done     = out_done_reg;

    // checks
    `include "periodic_ring_minmod_slope_top_assert.svh"

    // the divider only finishes while the sequencer waits on it
    `PRMM_ASSERT_NOW(a_div_done_in_wait, div_done, state_reg == ST_DIV, "divider done outside wait")

    // the ring's final result always belongs to cell 0
    `PRMM_ASSERT_NOW(a_ring_done_cell0, out_valid && ring_done, cell_index == '0, "ring_done on nonzero cell")

    // after the right slope the sequencer moves on to the minmod pick
    `PRMM_ASSERT_NEXT(a_pick_after_right, (state_reg == ST_WEIGH) && (sel_reg == SLOPE_RIGHT), state_reg == ST_PICK, "no pick after right slope")

endmodule

@@ tb/tb_periodic_ring_minmod_slope_top.sv @@
// self-checking testbench for the periodic ring minmod slope limiter
`timescale 1ns / 1ps

module tb_periodic_ring_minmod_slope_top;

    import prmm_pkg::*;

    // clock period in ns, reset length and the various cycle budgets
    localparam int CLK_PERIOD     = 8;
    localparam int RESET_CYCLES   = 12;
    localparam int SETTLE_CYCLES  = 16;    // covers a ring start item still in flight
    localparam int DRAIN_CYCLES   = 600;   // sized for a ring end item with three results
    localparam int HOLD_CYCLES    = 1500;  // long receiver hold-off, fills the block
    localparam int WATCHDOG_LIMIT = 8000;  // cycles with no item moved on either side
    localparam int IDLE_PERCENT   = 7;
    localparam int PHASE_ITEMS    = 64;

    localparam longint SLOPE_HI = 64'sd140737488355327;
    localparam longint SLOPE_LO = -SLOPE_HI - 64'sd1;

    localparam logic [WID_W-1:0] UNIT_WIDTH = 32'h1000_0000;  // 1.0 in q4.28

    // one cell item as driven into the block
    typedef struct packed {
        logic [VAL_W-1:0] value;
        logic [WID_W-1:0] width;
        logic             last;
    } cell_item_t;

    // one slope item as expected out of the block
    typedef struct packed {
        logic [IDX_W-1:0]   index;
        logic [SLOPE_W-1:0] slope;
        logic               done;
    } slope_item_t;

    // how the cells of a generated ring are filled
    typedef enum int {VAL_RANDOM, VAL_RAMP, VAL_EXTREME, VAL_FLAT} value_mode_e;
    typedef enum int {WID_RANDOM, WID_UNIT, WID_EXTREME} width_mode_e;

    logic                       clk = 1'b0;
    logic                       rst_n = 1'b0;
    logic                       psel = 1'b0;
    logic                       penable = 1'b0;
    logic                       pwrite = 1'b0;
    logic [APB_AW-1:0]          paddr = '0;
    logic [APB_DW-1:0]          pwdata = '0;
    logic [APB_DW-1:0]          prdata;
    logic                       pready;
    logic                       in_valid = 1'b0;
    logic                       in_stall;
    logic signed [VAL_W-1:0]    cell_value = '0;
    logic [WID_W-1:0]           cell_width = '0;
    logic                       ring_end = 1'b0;
    logic                       out_valid;
    logic                       out_stall = 1'b0;
    logic [IDX_W-1:0]           cell_index;
    logic signed [SLOPE_W-1:0]  limited_slope;
    logic                       ring_done;

    // stimulus waiting for the driver, and slopes waiting for the block
    cell_item_t  cell_queue[$];
    slope_item_t slope_queue[$];

    // predictor copy of the block's register and ring state
    logic [FACT_W-1:0] factor_model = FACT_RESET;
    longint            head_val[2];
    longint unsigned   head_wid[2];
    longint            prev_val[2];
    longint unsigned   prev_wid[2];
    int                ring_pos = 0;

    // run control shared between the sequencer and the clocked processes
    bit quiet = 1'b0;          // no idling on either side while set
    bit hold_request = 1'b0;   // asks the receiver for its one long hold-off
    int hold_left = 0;
    bit hold_taken = 1'b0;

    // bookkeeping for the checks and the closing summary
    int error_count = 0;
    int cells_pushed = 0;
    int rings_closed = 0;
    int slopes_checked = 0;
    int nonzero_expected = 0;
    int saturated_expected = 0;
    int stall_cycles = 0;
    cell_item_t next_cell;

    periodic_ring_minmod_slope_top u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .cell_value    (cell_value),
        .cell_width    (cell_width),
        .ring_end      (ring_end),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .cell_index    (cell_index),
        .limited_slope (limited_slope),
        .ring_done     (ring_done)
    );

    initial
    begin
        forever #(CLK_PERIOD / 2) clk = ~clk;
    end

    // one line per mismatch, and a count for the final verdict
    task automatic report_mismatch(input string what);
        $display("[%0t] mismatch: %s", $time, what);
        error_count++;
    endtask

    // ------------------------------------------------------------------
    // slope predictor
    // ------------------------------------------------------------------

    // |diff| * 2^29 / den, truncated, signed back and clamped to 48 bits;
    // an empty denominator gives a flat slope
    function automatic longint quotient_slope(input longint diff, input longint unsigned den);
        longint unsigned mag;
        longint unsigned quo;
        longint unsigned cap;
        cap = SLOPE_HI;
        if (den == 0)
            return 0;
        mag = (diff < 0) ? -diff : diff;
        quo = (mag << FRAC_SHIFT) / den;
        if (diff < 0)
            return (quo > cap + 1) ? SLOPE_LO : -longint'(quo);
        return (quo > cap) ? SLOPE_HI : longint'(quo);
    endfunction

    // slope times the factor in eighths, truncated toward zero, clamped
    function automatic longint weighted(input longint s, input logic [FACT_W-1:0] f);
        longint prod;
        prod = s * longint'(f);
        prod = prod / 8;
        if (prod > SLOPE_HI)
            return SLOPE_HI;
        if (prod < SLOPE_LO)
            return SLOPE_LO;
        return prod;
    endfunction

    function automatic longint mag_of(input longint v);
        return (v < 0) ? -v : v;
    endfunction

    // generalized minmod of f*left, centre and f*right for one cell;
    // on equal magnitudes left wins over centre, centre over right
    function automatic longint minmod3(input longint vl, input longint unsigned wl,
                                       input longint vc, input longint unsigned wc,
                                       input longint vr, input longint unsigned wr);
        longint lt;
        longint ct;
        longint rt;
        longint best;
        lt = weighted(quotient_slope(vc - vl, wc + wl), factor_model);
        rt = weighted(quotient_slope(vr - vc, wr + wc), factor_model);
        ct = quotient_slope(vr - vl, wl + wr + 2 * wc);
        // any sign disagreement or a zero operand flattens the slope
        if (!((lt > 0 && ct > 0 && rt > 0) || (lt < 0 && ct < 0 && rt < 0)))
            return 0;
        best = lt;
        if (mag_of(ct) < mag_of(best))
            best = ct;
        if (mag_of(rt) < mag_of(best))
            best = rt;
        return best;
    endfunction

    task automatic push_slope(input int idx, input longint s, input bit done);
        slope_item_t e;
        e.index = IDX_W'(idx);
        e.slope = s[SLOPE_W-1:0];
        e.done  = done;
        if (s != 0)
            nonzero_expected++;
        if (s == SLOPE_HI || s == SLOPE_LO)
            saturated_expected++;
        slope_queue.push_back(e);
    endtask

    // advance the ring state by one accepted cell and queue its slopes
    task automatic predict_cell(input cell_item_t c);
        longint          v;
        longint unsigned w;
        bit              closing;
        int              k;
        v = longint'($signed(c.value));
        w = 64'(c.width);
        k = ring_pos;
        // a ring that reaches the length limit closes by itself
        closing = c.last || (k + 1 >= MAX_CELLS);
        if (k == 0)
        begin
            head_val[0] = v;
            head_wid[0] = w;
        end
        if (k == 1)
        begin
            head_val[1] = v;
            head_wid[1] = w;
        end
        // the previous cell now has its right neighbor
        if (k >= 2)
            push_slope(k - 1, minmod3(prev_val[1], prev_wid[1], prev_val[0], prev_wid[0],
                                      v, w), 1'b0);
        if (closing)
        begin
            if (k == 0)
            begin
                // lone cell is its own neighbor on both sides
                push_slope(0, minmod3(v, w, v, w, v, w), 1'b1);
            end
            else if (k == 1)
            begin
                // two cells: each is both neighbors of the other
                push_slope(1, minmod3(head_val[0], head_wid[0], v, w,
                                      head_val[0], head_wid[0]), 1'b0);
                push_slope(0, minmod3(v, w, head_val[0], head_wid[0], v, w), 1'b1);
            end
            else
            begin
                // last cell wraps to cell 0, then cell 0 wraps back to the last
                push_slope(k, minmod3(prev_val[0], prev_wid[0], v, w,
                                      head_val[0], head_wid[0]), 1'b0);
                push_slope(0, minmod3(v, w, head_val[0], head_wid[0],
                                      head_val[1], head_wid[1]), 1'b1);
            end
            ring_pos = 0;
            rings_closed++;
        end
        else
        begin
            ring_pos = k + 1;
        end
        prev_val[1] = prev_val[0];
        prev_wid[1] = prev_wid[0];
        prev_val[0] = v;
        prev_wid[0] = w;
    endtask

    // ------------------------------------------------------------------
    // cell driver: presents queued items, holds them while stalled,
    // idles now and then unless the run is in a quiet stretch
    // ------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid   <= 1'b0;
            cell_value <= '0;
            cell_width <= '0;
            ring_end   <= 1'b0;
        end
        else
        begin
            if (in_valid && !in_stall)
                predict_cell({cell_value, cell_width, ring_end});
            // a new item may go out once the current one is gone or none is up
            if (!in_valid || !in_stall)
            begin
                if (cell_queue.size() > 0 && (quiet || $urandom_range(99) >= IDLE_PERCENT))
                begin
                    next_cell = cell_queue.pop_front();
                    in_valid   <= 1'b1;
                    cell_value <= next_cell.value;
                    cell_width <= next_cell.width;
                    ring_end   <= next_cell.last;
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // receiver stall: random back-pressure plus one long hold-off that
    // lets the output register fill and pushes the stall back to the input
    // ------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_stall  <= 1'b0;
            hold_left  = 0;
            hold_taken = 1'b0;
        end
        else if (hold_request && !hold_taken)
        begin
            hold_taken = 1'b1;
            hold_left  = HOLD_CYCLES;
            out_stall <= 1'b1;
        end
        else if (hold_left > 0)
        begin
            hold_left--;
            out_stall <= 1'b1;
        end
        else
        begin
            out_stall <= !quiet && ($urandom_range(99) < IDLE_PERCENT);
        end
    end

    // ------------------------------------------------------------------
    // slope monitor: every accepted item against the oldest expectation
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (rst_n && in_valid && in_stall)
            stall_cycles++;
        if (rst_n && out_valid && !out_stall)
        begin
            if (slope_queue.size() == 0)
            begin
                report_mismatch($sformatf("unexpected slope item, cell %0d slope %0d",
                                          cell_index, limited_slope));
            end
            else
            begin
                slopes_checked++;
                if (cell_index !== slope_queue[0].index)
                    report_mismatch($sformatf("cell_index got %0d want %0d",
                                              cell_index, slope_queue[0].index));
                if (limited_slope !== slope_queue[0].slope)
                    report_mismatch($sformatf("cell %0d limited_slope got %0d want %0d",
                                              slope_queue[0].index, limited_slope,
                                              $signed(slope_queue[0].slope)));
                if (ring_done !== slope_queue[0].done)
                    report_mismatch($sformatf("cell %0d ring_done got %0b want %0b",
                                              slope_queue[0].index, ring_done,
                                              slope_queue[0].done));
                void'(slope_queue.pop_front());
            end
        end
    end

    // ------------------------------------------------------------------
    // watchdog: ends the run if neither side moves an item for too long
    // ------------------------------------------------------------------
    int quiet_cycles = 0;
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("[%0t] watchdog: no item moved for %0d cycles", $time, quiet_cycles);
                $display("FAIL");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------

    task automatic push_cell(input logic [VAL_W-1:0] v, input logic [WID_W-1:0] w,
                             input logic last);
        cell_item_t c;
        c.value = v;
        c.width = w;
        c.last  = last;
        cell_queue.push_back(c);
        cells_pushed++;
    endtask

    // one ring of n cells; when mark_last is clear the ring runs unmarked
    task automatic add_ring(input int n, input value_mode_e vmode, input width_mode_e wmode,
                            input bit mark_last);
        logic [VAL_W-1:0] base;
        logic [VAL_W-1:0] v;
        logic [WID_W-1:0] w;
        int               step;
        bit               noisy;
        base  = $urandom;
        step  = int'($urandom_range(0, 2 ** 21)) - 2 ** 20;
        noisy = 1'($urandom_range(1));
        for (int i = 0; i < n; i++)
        begin
            case (vmode)
                VAL_RAMP:
                    v = base + VAL_W'(i * step) + (noisy ? VAL_W'($urandom_range(0, 4095)) : '0);
                VAL_EXTREME:
                    case ($urandom_range(3))
                        0:       v = 32'h8000_0000;
                        1:       v = 32'h7fff_ffff;
                        2:       v = 32'h0000_0000;
                        default: v = 32'hffff_ffff;
                    endcase
                VAL_FLAT:
                    v = base;
                default:
                    v = $urandom;
            endcase
            case (wmode)
                WID_UNIT:
                    w = UNIT_WIDTH + (noisy ? WID_W'($urandom_range(0, 32'h00ff_ffff)) : '0);
                WID_EXTREME:
                    w = $urandom_range(1) ? 32'hffff_ffff : 32'd1;
                default:
                    w = $urandom;
            endcase
            if (w == 0)
                w = 1;
            push_cell(v, w, mark_last && (i == n - 1));
        end
    endtask

    // rings of random shape until about n cells are queued
    task automatic add_random_rings(input int n);
        int          target;
        int          len;
        int          pick;
        value_mode_e vm;
        width_mode_e wm;
        target = cells_pushed + n;
        while (cells_pushed < target)
        begin
            pick = $urandom_range(99);
            if (pick < 10)
                len = $urandom_range(1, 2);
            else if (pick < 75)
                len = $urandom_range(3, 8);
            else
                len = $urandom_range(9, 40);
            pick = $urandom_range(99);
            if (pick < 45)
                vm = VAL_RAMP;
            else if (pick < 70)
                vm = VAL_RANDOM;
            else if (pick < 85)
                vm = VAL_EXTREME;
            else
                vm = VAL_FLAT;
            pick = $urandom_range(99);
            if (pick < 40)
                wm = WID_RANDOM;
            else if (pick < 85)
                wm = WID_UNIT;
            else
                wm = WID_EXTREME;
            add_ring(len, vm, wm, 1'b1);
        end
    endtask

    // sender pause: every queued cell taken and every slope back, then SETTLE_CYCLES
    // more in case the last item was a ring start still in flight;
    // polled on the falling edge so that all rising-edge updates are settled
    task automatic wait_drained();
        while (cell_queue.size() > 0 || in_valid || slope_queue.size() > 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // apb write of the limiter factor, then a read back of the register
    task automatic set_factor(input logic [FACT_W-1:0] f);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {REG_LIMITER_FACTOR, 2'b00};
        pwdata  <= APB_DW'(f);
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        // write taken at this edge, the read setup follows straight on
        factor_model = f;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        if (prdata[FACT_W-1:0] !== f)
            report_mismatch($sformatf("limiter_factor read back %0d want %0d",
                                      prdata[FACT_W-1:0], f));
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // ------------------------------------------------------------------
    // sequencer
    // ------------------------------------------------------------------
    initial
    begin
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed rings at the reset factor of 1.5
        // lone cells at the field extremes: always flat
        push_cell(32'h7fff_ffff, 32'hffff_ffff, 1'b1);
        push_cell(32'h8000_0000, 32'd1, 1'b1);
        // two-cell rings with the widest value swing, narrow then wide cells
        push_cell(32'h8000_0000, 32'd1, 1'b0);
        push_cell(32'h7fff_ffff, 32'd1, 1'b1);
        push_cell(32'h7fff_ffff, 32'hffff_ffff, 1'b0);
        push_cell(32'h8000_0000, 32'hffff_ffff, 1'b1);
        // three cells with uneven widths
        push_cell(32'h0000_0000, UNIT_WIDTH, 1'b0);
        push_cell(32'h0001_0000, UNIT_WIDTH, 1'b0);
        push_cell(32'h0003_0000, 32'h2000_0000, 1'b1);
        // clean ramp, the middle cells see agreeing slopes
        push_cell(32'h0000_0000, UNIT_WIDTH, 1'b0);
        push_cell(32'h0001_0000, UNIT_WIDTH, 1'b0);
        push_cell(32'h0002_0000, UNIT_WIDTH, 1'b0);
        push_cell(32'h0003_0000, UNIT_WIDTH, 1'b1);
        // zigzag, every cell sees slopes that disagree in sign or a flat one
        push_cell(32'h0005_0000, UNIT_WIDTH, 1'b0);
        push_cell(32'hfffb_0000, UNIT_WIDTH, 1'b0);
        push_cell(32'h0005_0000, UNIT_WIDTH, 1'b0);
        push_cell(32'hfffb_0000, UNIT_WIDTH, 1'b0);
        push_cell(32'h0005_0000, UNIT_WIDTH, 1'b1);
        // rising values over alternating extreme widths
        push_cell(32'h0000_0000, 32'd1, 1'b0);
        push_cell(32'h0100_0000, 32'hffff_ffff, 1'b0);
        push_cell(32'h0200_0000, 32'd1, 1'b0);
        push_cell(32'h7fff_ffff, 32'hffff_ffff, 1'b1);
        wait_drained();

        // factor 1.0: an exact ramp makes the three operands of the inner cells tie
        set_factor(FACT_W'(8));
        for (int i = 0; i < 6; i++)
            push_cell(VAL_W'(i * 32'h0002_0000), UNIT_WIDTH, i == 5);
        add_random_rings(PHASE_ITEMS);
        wait_drained();

        // factor 2.0, with the long receiver hold-off while cells keep coming
        set_factor(FACT_W'(16));
        add_random_rings(PHASE_ITEMS);
        hold_request <= 1'b1;
        wait_drained();

        // factor 0 flattens everything, factor 31 is the top of the field
        set_factor(FACT_W'(0));
        add_random_rings(PHASE_ITEMS / 2);
        wait_drained();
        set_factor(FACT_W'(31));
        add_random_rings(PHASE_ITEMS / 2);
        wait_drained();

        // random factors inside the usual range
        for (int p = 0; p < 2; p++)
        begin
            set_factor(FACT_W'($urandom_range(8, 16)));
            add_random_rings(PHASE_ITEMS / 2);
            wait_drained();
        end

        // a long stretch with no idling on either side, closed by a short ring
        quiet <= 1'b1;
        set_factor(FACT_RESET);
        add_random_rings(PHASE_ITEMS / 2);
        add_ring(3, VAL_RAMP, WID_RANDOM, 1'b1);
        wait_drained();
        quiet <= 1'b0;

        // anything the block still sends now has no expectation behind it
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("covered %0d cells in %0d rings, lone and two-cell rings, extreme values",
                 cells_pushed, rings_closed);
        $display("checked %0d slopes, %0d nonzero and %0d clamped, factors 0 to 31, %0d stalled input cycles",
                 slopes_checked, nonzero_expected, saturated_expected, stall_cycles);
        if (error_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
